### rtl/sqs_pkg.sv
// types, constants and the subband lookup for the subband quantization shift block
// no dependencies; imported by every module of the block

package sqs_pkg;

    localparam int QT_W      = 40;
    localparam int NIB_CNT   = 10;
    localparam int POS_W     = 12;
    localparam int COEF_W    = 16;
    localparam int SHIFT_W   = 4;
    localparam int PDATA_W   = 64;
    localparam int PADDR_W   = 4;
    localparam int Q_DEPTH   = 2;

    localparam logic [QT_W-1:0]    QT_RESET  = 40'h6666666666;
    localparam logic [POS_W-1:0]   POS_LAST  = 12'd4095;
    localparam logic [3:0]         Q_NOSHIFT = 4'd6;
    localparam logic [SHIFT_W-1:0] BASE_SH   = 4'd5;

    // register index carried by paddr[3]
    localparam logic REG_QUANT_TABLE = 1'b0;

    // subband region starts
    localparam logic [POS_W-1:0] B_LH1 = 12'd1024;
    localparam logic [POS_W-1:0] B_HH1 = 12'd2048;
    localparam logic [POS_W-1:0] B_HL2 = 12'd3072;
    localparam logic [POS_W-1:0] B_LH2 = 12'd3328;
    localparam logic [POS_W-1:0] B_HH2 = 12'd3584;
    localparam logic [POS_W-1:0] B_HL3 = 12'd3840;
    localparam logic [POS_W-1:0] B_LH3 = 12'd3904;
    localparam logic [POS_W-1:0] B_HH3 = 12'd3968;
    localparam logic [POS_W-1:0] B_LL3 = 12'd4032;

    // nibble index of each subband in the quantizer table
    localparam logic [3:0] NIB_LL3 = 4'd0;
    localparam logic [3:0] NIB_LH3 = 4'd1;
    localparam logic [3:0] NIB_HL3 = 4'd2;
    localparam logic [3:0] NIB_HH3 = 4'd3;
    localparam logic [3:0] NIB_LH2 = 4'd4;
    localparam logic [3:0] NIB_HL2 = 4'd5;
    localparam logic [3:0] NIB_HH2 = 4'd6;
    localparam logic [3:0] NIB_LH1 = 4'd7;
    localparam logic [3:0] NIB_HL1 = 4'd8;
    localparam logic [3:0] NIB_HH1 = 4'd9;

    typedef struct packed {
        logic                     mode;
        logic signed [COEF_W-1:0] coeff;
        logic [SHIFT_W-1:0]       shift;
        logic                     last;
    } t_entry;

    function automatic logic [3:0] nibble_for_pos(input logic [POS_W-1:0] pos);
        logic [3:0] k;
        if (pos < B_LH1)      k = NIB_HL1;
        else if (pos < B_HH1) k = NIB_LH1;
        else if (pos < B_HL2) k = NIB_HH1;
        else if (pos < B_LH2) k = NIB_HL2;
        else if (pos < B_HH2) k = NIB_LH2;
        else if (pos < B_HL3) k = NIB_HH2;
        else if (pos < B_LH3) k = NIB_HL3;
        else if (pos < B_HH3) k = NIB_LH3;
        else if (pos < B_LL3) k = NIB_HH3;
        else                  k = NIB_LL3;
        return k;
    endfunction

endpackage

### rtl/sqs_front.sv
// front end: quantizer table register, tile position counter and subband classification
// depends on sqs_pkg

module sqs_front import sqs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    input  logic               i_in_valid,
    input  logic               i_mode,
    input  logic signed [COEF_W-1:0] i_coeff_in,
    input  logic               i_q_ready,
    output logic               o_push,
    output t_entry             o_entry
);

    logic [QT_W-1:0]  r_qtab, n_qtab;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [3:0]       w_nib;
    logic [3:0]       w_q;
    logic             w_wr;

    assign w_wr = psel && penable && pwrite && (paddr[3] == REG_QUANT_TABLE);

    always_comb begin
        n_qtab = w_wr ? pwdata[QT_W-1:0] : r_qtab;
    end

    assign prdata = (paddr[3] == REG_QUANT_TABLE) ? {{(PDATA_W-QT_W){1'b0}}, r_qtab} : '0;

    assign o_push = i_in_valid && i_q_ready;

    always_comb begin
        n_pos = o_push ? r_pos + 1'b1 : r_pos;
    end

    assign w_nib = nibble_for_pos(r_pos);
    assign w_q   = r_qtab[{w_nib, 2'b00} +: 4];

    always_comb begin
        o_entry.mode  = i_mode;
        o_entry.coeff = i_coeff_in;
        o_entry.shift = (w_q > Q_NOSHIFT) ? w_q - Q_NOSHIFT : '0;
        o_entry.last  = (r_pos == POS_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qtab <= QT_RESET;
            r_pos  <= '0;
        end else begin
            r_qtab <= n_qtab;
            r_pos  <= n_pos;
        end
    end

endmodule

### rtl/sqs_queue.sv
// two-entry queue between the classifier front end and the shift back end
// depends on sqs_pkg

module sqs_queue import sqs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_ready,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int PTR_W = $clog2(Q_DEPTH);

    t_entry                r_mem [Q_DEPTH];
    logic [PTR_W-1:0]      r_wr, n_wr;
    logic [PTR_W-1:0]      r_rd, n_rd;
    logic [PTR_W:0]        r_cnt, n_cnt;
    logic                  w_pop;

    assign o_ready = (r_cnt != PTR_W'(0) + (PTR_W+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = w_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (PTR_W+1)'(i_push) - (PTR_W+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

### rtl/sqs_back.sv
// back end: quantize or dequantize shift and the registered output word
// depends on sqs_pkg

module sqs_back import sqs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_q_valid,
    input  t_entry i_entry,
    output logic   o_pop,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output logic signed [COEF_W-1:0] o_coeff_out,
    output logic   o_last_of_tile
);

    logic                     r_valid, n_valid;
    logic signed [COEF_W-1:0] r_coeff;
    logic                     r_last;
    logic signed [17:0]       w_x, w_rnd, w_y, w_z;
    logic [COEF_W-1:0]        w_dec;
    logic [SHIFT_W-1:0]       w_dsh;
    logic signed [COEF_W-1:0] w_res;

    assign o_pop = i_q_valid && (!r_valid || i_out_ready);

    always_comb begin
        // encode: round off the quantizer shift, then the fixed shift by five
        w_x   = 18'(i_entry.coeff);
        w_rnd = (i_entry.shift == '0) ? 18'sd0 : (18'sd1 <<< (i_entry.shift - 4'd1));
        w_y   = (w_x + w_rnd) >>> i_entry.shift;
        w_z   = (w_y + 18'sd16) >>> 5;
        // decode: wrap to the word width
        w_dsh = BASE_SH + i_entry.shift;
        w_dec = COEF_W'(i_entry.coeff) << w_dsh;
        w_res = i_entry.mode ? w_z[COEF_W-1:0] : w_dec;
    end

    always_comb begin
        n_valid = o_pop || (r_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_coeff <= w_res;
            r_last  <= i_entry.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_coeff_out    = r_coeff;
    assign o_last_of_tile = r_last;

endmodule

### rtl/subband_quant_shift.sv
// subband quantization shift: a word taken at the input is written into the queue,
// then into the output register; throughput one word per cycle while the output is
// not stalled, set by the combinational shift unit in sqs_back
// the two-entry queue and the output register hold three words under a stalled output
// synchronous active-low reset clears position counter, queue and output valid
// and loads every quantizer with six
module subband_quant_shift import sqs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic signed [COEF_W-1:0] i_coeff_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [COEF_W-1:0] o_coeff_out,
    output logic               o_last_of_tile
);

    logic   w_push, w_q_ready, w_q_valid, w_pop;
    t_entry w_fe_entry, w_be_entry;

    assign pready     = 1'b1;
    assign o_in_ready = w_q_ready;

    sqs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_coeff_in (i_coeff_in),
        .i_q_ready  (w_q_ready),
        .o_push     (w_push),
        .o_entry    (w_fe_entry)
    );

    sqs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_fe_entry),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_be_entry)
    );

    sqs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_entry        (w_be_entry),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_coeff_out    (o_coeff_out),
        .o_last_of_tile (o_last_of_tile)
    );

endmodule

### rtl/sqs_checker.sv
// port-level checks for subband_quant_shift, attached with a bind
// depends on sqs_pkg

module sqs_checker import sqs_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [COEF_W-1:0] o_coeff_out,
    input logic               o_last_of_tile
);

    // output valid is cleared by reset
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // input only backs up when an output word is waiting
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // table readback follows a write
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && (paddr[3] == REG_QUANT_TABLE)) |=>
        (paddr[3] != REG_QUANT_TABLE || prdata[QT_W-1:0] == $past(pwdata[QT_W-1:0])))
        else $error("quantizer table readback mismatch");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_coeff_out) && $stable(o_last_of_tile)))
        else $error("stalled output word changed");

endmodule

bind subband_quant_shift sqs_checker u_sqs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_coeff_out    (o_coeff_out),
    .o_last_of_tile (o_last_of_tile)
);
